### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GTSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gtsa_pkg.sv
// ----------------------------------------------------------------------------
// gtsa_pkg
// Shared types and constants of the generation-tagged slot allocator.
// ----------------------------------------------------------------------------
package gtsa_pkg;

  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = 11;   // slots_in_use register width
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned STATUS_W  = 3;

  // slot count after reset: register reset value, saturated at the pool size
  localparam int unsigned RESET_SLOTS = (1024 > MAX_SLOTS) ? MAX_SLOTS : 1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RELEASED = 3'd2,
    ST_RANGE    = 3'd3,
    ST_STALE    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // free stack commands
  typedef struct packed {
    logic refill;  // reload stack with count-1 .. 0
    logic rd;      // read top entry
    logic pop;
    logic push;
  } stk_cmd_t;

endpackage

### rtl/core/generation_tagged_slot_allocator.sv
// ----------------------------------------------------------------------------
// generation_tagged_slot_allocator
// Slot pool with a LIFO free stack and a 32-bit generation per slot.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid_i / in_stall_o): mode_i 0 acquires the top free
//   slot, mode_i 1 releases slot_index_i with slot_generation_i.
//   Result channel (out_valid_o / out_stall_i): one beat per request with
//   status_o, granted_index_o and granted_generation_o (zero unless acquired).
//   Config channel (cfg_valid_i / cfg_ready_o, always ready): cfg_data_i sets
//   slots_in_use (saturated at MAX_SLOTS), refills the stack and clears all
//   generations.
// Timing
//   One request in flight at a time. An acquire that pops steps through a
//   stack RAM read, then a generation RAM read, then the decision and
//   write-back; a release reads the generation RAM, then decides; an acquire
//   on an empty pool goes straight to the decision. The RAM reads are serial.
//   After reset and after every config write a clearing pass zeroes the
//   generation RAM, one entry a cycle, with in_stall_o high until all MAX_SLOTS
//   (1024) entries are clear. The stack refill is immediate (low-mark scheme).
// Back-pressure
//   The result sits in an output register. While out_stall_i holds it, a new
//   request is still taken and worked up to its final step, which waits for
//   the register to free.
// ----------------------------------------------------------------------------
module generation_tagged_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gtsa_pkg::CNT_W-1:0]    cfg_data_i,
  // request
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [gtsa_pkg::IDX_W-1:0]    slot_index_i,
  input  logic [gtsa_pkg::GEN_W-1:0]    slot_generation_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gtsa_pkg::STATUS_W-1:0] status_o,
  output logic [gtsa_pkg::IDX_W-1:0]    granted_index_o,
  output logic [gtsa_pkg::GEN_W-1:0]    granted_generation_o
);
  import gtsa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_STACK = 4'b0100,
    S_GEN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // request being worked on
  logic             mode_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_in_q;
  logic [IDX_W-1:0] slot_q;

  // output register
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [GEN_W-1:0]    out_gen_q, out_gen_d;

  logic             cfg_wr;
  logic             in_acc;
  logic             out_free;
  logic             out_load;
  stk_cmd_t         stk_cmd;
  logic [CNT_W-1:0] stk_depth;
  logic [IDX_W-1:0] stk_top;

  logic             gen_we, gen_re;
  logic [IDX_W-1:0] gen_waddr, gen_raddr;
  logic [GEN_W-1:0] gen_wdata, gen_rdata, gen_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign gen_inc     = gen_rdata + GEN_W'(1);

  // saturate the written count at the pool size
  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      count_d = (cfg_data_i > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    stk_cmd      = '0;
    gen_we       = 1'b0;
    gen_waddr    = slot_q;
    gen_wdata    = gen_inc;
    gen_re       = 1'b0;
    gen_raddr    = slot_index_i;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_idx_d    = '0;
    out_gen_d    = '0;

    unique case (state_q)
      S_CLEAR: begin
        gen_we    = 1'b1;
        gen_waddr = clr_q;
        gen_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            gen_re  = 1'b1;
            state_d = S_GEN;
          end else if (stk_depth != '0) begin
            stk_cmd.rd = 1'b1;
            state_d    = S_STACK;
          end else begin
            state_d = S_GEN;
          end
        end
      end
      S_STACK: begin
        gen_re    = 1'b1;
        gen_raddr = stk_top;
        state_d   = S_GEN;
      end
      S_GEN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (!mode_q) begin
            if (stk_depth == '0) begin
              out_status_d = ST_EMPTY;
            end else begin
              out_status_d = ST_ACQUIRED;
              out_idx_d    = slot_q;
              out_gen_d    = gen_inc;
              gen_we       = 1'b1;
              stk_cmd.pop  = 1'b1;
            end
          end else begin
            priority if ({1'b0, idx_q} >= count_q) begin
              out_status_d = ST_RANGE;
            end else if (gen_rdata != gen_in_q) begin
              out_status_d = ST_STALE;
            end else if (stk_depth >= count_q) begin
              out_status_d = ST_FULL;
            end else begin
              out_status_d = ST_RELEASED;
              stk_cmd.push = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // a config write aborts any work and restarts the clearing pass
    if (cfg_wr) begin
      stk_cmd        = '0;
      stk_cmd.refill = 1'b1;
      out_load       = 1'b0;
      state_d        = S_CLEAR;
      clr_d          = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= CNT_W'(RESET_SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= mode_i;
      idx_q    <= slot_index_i;
      gen_in_q <= slot_generation_i;
    end
    if (state_q == S_STACK) begin
      slot_q <= stk_top;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_gen_q    <= out_gen_d;
    end
  end

  gtsa_free_stack u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .n_i         (count_d),
    .push_data_i (idx_q),
    .depth_o     (stk_depth),
    .top_o       (stk_top)
  );

  gtsa_ram #(
    .WIDTH (GEN_W),
    .DEPTH (MAX_SLOTS)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign granted_index_o      = out_idx_q;
  assign granted_generation_o = out_gen_q;

endmodule

### rtl/core/gtsa_ram.sv
// ----------------------------------------------------------------------------
// gtsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/gtsa_free_stack.sv
// ----------------------------------------------------------------------------
// gtsa_free_stack
// LIFO of free slot indices in RAM, refilled without RAM writes via a low mark.
// ----------------------------------------------------------------------------
module gtsa_free_stack (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gtsa_pkg::stk_cmd_t      cmd_i,
  input  logic [gtsa_pkg::CNT_W-1:0] n_i,
  input  logic [gtsa_pkg::IDX_W-1:0] push_data_i,
  output logic [gtsa_pkg::CNT_W-1:0] depth_o,
  output logic [gtsa_pkg::IDX_W-1:0] top_o
);
  import gtsa_pkg::*;

  logic [CNT_W-1:0] depth_q, depth_d;
  // lowest depth since refill: entries below it still hold refill contents
  logic [CNT_W-1:0] low_q, low_d;
  logic             sel_init_q;
  logic [IDX_W-1:0] init_q;
  logic [CNT_W-1:0] depth_m1;
  logic [IDX_W-1:0] ram_rdata;

  assign depth_m1 = depth_q - CNT_W'(1);

  always_comb begin
    depth_d = depth_q;
    low_d   = low_q;
    priority if (cmd_i.refill) begin
      depth_d = n_i;
      low_d   = n_i;
    end else if (cmd_i.pop) begin
      depth_d = depth_m1;
      if (depth_m1 < low_q) begin
        low_d = depth_m1;
      end
    end else if (cmd_i.push) begin
      depth_d = depth_q + CNT_W'(1);
    end else begin
      depth_d = depth_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= CNT_W'(RESET_SLOTS);
      low_q      <= CNT_W'(RESET_SLOTS);
      sel_init_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      low_q   <= low_d;
      if (cmd_i.rd) begin
        sel_init_q <= (depth_m1 < low_q);
      end
    end
  end

  // refill value of entry p is n-1-p; for p = depth-1 that is n-depth
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      init_q <= IDX_W'(n_i - depth_q);
    end
  end

  gtsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && !cmd_i.refill),
    .waddr_i (depth_q[IDX_W-1:0]),
    .wdata_i (push_data_i),
    .re_i    (cmd_i.rd),
    .raddr_i (depth_m1[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign top_o   = sel_init_q ? init_q : ram_rdata;
  assign depth_o = depth_q;

endmodule

### rtl/core/gtsa_checker.sv
// ----------------------------------------------------------------------------
// gtsa_checker
// Port-level assertions for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [gtsa_pkg::STATUS_W-1:0] status_o,
  input logic [gtsa_pkg::IDX_W-1:0]    granted_index_o,
  input logic [gtsa_pkg::GEN_W-1:0]    granted_generation_o
);
  import gtsa_pkg::*;

  // one request in flight: accepting one closes the input next cycle
  `GTSA_ASSERT_NXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second request taken")

  // a config write starts the clearing pass
  `GTSA_ASSERT_NXT(a_cfg_clears, cfg_valid_i && cfg_ready_o, in_stall_o, "no clear after config")

  // failed requests carry no grant
  `GTSA_ASSERT_IMP(a_fail_zero, out_valid_o && (status_o != ST_ACQUIRED),
                   (granted_index_o == '0) && (granted_generation_o == '0),
                   "grant fields set on failure")

  // held result beat stays
  `GTSA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  `GTSA_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i,
                   $stable(status_o) && $stable(granted_generation_o),
                   "result changed while stalled")

endmodule

bind generation_tagged_slot_allocator gtsa_checker u_gtsa_checker (.*);
